@@ hdl/dwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsp_pkg: shared definitions for the dual wheel speed PID unit
// Register indexes, reset values, fixed-point scale constants, thresholds and
// the divider status bundle.
// ----------------------------------------------------------------------------
package dwsp_pkg;

	// build defaults
	localparam int SUM_WIDTH_DEF = 32;
	localparam int CMD_LIMIT_DEF = 255;

	// configuration register map
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_MM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;

	localparam logic [15:0] MM_RESET     = 16'd6554;
	localparam logic [15:0] GAIN_P_RESET = 16'h0100;
	localparam logic [15:0] GAIN_I_RESET = 16'h0000;
	localparam logic [15:0] GAIN_D_RESET = 16'h0000;

	// shared multiplier: second operand is signed 17 bits
	localparam int MUL_BW = 17;

	// speed = ticks * mm * 1e6 / (interval * 2^16) = (ticks * mm * 15625 >> 10) / interval
	localparam logic [16:0] SPD_SCALE   = 17'd15625;
	localparam int          SCALE_SHIFT = 10;
	localparam int          MM_PROD_W   = 30;

	// iterative divider
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 20;
	localparam int DIV_Q_W   = 16;
	localparam int DIV_CNT_W = 4;

	localparam logic [15:0] SPEED_MAX = 16'h7FFF;
	localparam logic [15:0] SPEED_MIN = 16'h8000;
	localparam logic [15:0] QUO_NEG_MAX = 16'h8000;

	// slip and stall thresholds
	localparam int SLIP_CMD_MIN  = 50;
	localparam int SLIP_SPD_LIM  = 4;
	localparam int STALL_CMD_MIN = 100;
	localparam int STALL_SPD_LIM = 5;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

@@ hdl/dwsp_mul.sv @@
// ----------------------------------------------------------------------------
// dwsp_mul: shared signed multiplier
// One signed product per cycle with a registered result.
// ----------------------------------------------------------------------------
module dwsp_mul #(
	parameter int A_W = 32
) (
	input  logic                                  clk,
	input  logic signed [A_W-1:0]                 a,
	input  logic signed [dwsp_pkg::MUL_BW-1:0]    b,
	output logic signed [A_W+dwsp_pkg::MUL_BW-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= (A_W + dwsp_pkg::MUL_BW)'(a) * (A_W + dwsp_pkg::MUL_BW)'(b);
	end

endmodule

@@ hdl/dwsp_div.sv @@
// ----------------------------------------------------------------------------
// dwsp_div: iterative restoring divider
// Divides a 36-bit numerator by a 20-bit denominator, one quotient bit per
// cycle for 16 bits; a quotient of 2^16 or more is flagged as overflow.
// ----------------------------------------------------------------------------
module dwsp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [dwsp_pkg::DIV_NUM_W-1:0]     num,
	input  logic [dwsp_pkg::DIV_DEN_W-1:0]     den,
	output dwsp_pkg::div_stat_t                stat,
	output logic [dwsp_pkg::DIV_Q_W-1:0]       quo
);

	localparam logic [dwsp_pkg::DIV_CNT_W-1:0] CNT_LAST =
		dwsp_pkg::DIV_CNT_W'(dwsp_pkg::DIV_Q_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [dwsp_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                              ovf_q;
	logic [dwsp_pkg::DIV_DEN_W-1:0]    rem_q;
	logic [dwsp_pkg::DIV_DEN_W-1:0]    den_q;
	logic [dwsp_pkg::DIV_Q_W-1:0]      quo_q;
	logic [dwsp_pkg::DIV_DEN_W:0]      trial;
	logic [dwsp_pkg::DIV_DEN_W:0]      diff;
	logic                              ge;

	assign trial = {rem_q, quo_q[dwsp_pkg::DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the low numerator bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[dwsp_pkg::DIV_NUM_W-1:dwsp_pkg::DIV_Q_W];
			quo_q <= num[dwsp_pkg::DIV_Q_W-1:0];
			den_q <= den;
			ovf_q <= num[dwsp_pkg::DIV_NUM_W-1:dwsp_pkg::DIV_Q_W] >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[dwsp_pkg::DIV_DEN_W-1:0] : trial[dwsp_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[dwsp_pkg::DIV_Q_W-2:0], ge};
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quo       = quo_q;

endmodule

@@ hdl/dual_wheel_speed_pid_unit.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_unit: two-wheel speed measurement and PID velocity loop
// Requests are taken one at a time: the input is ready only while idle, and
// each wheel in turn goes through the shared multiplier, a wait on the shared
// bit-serial divider, the error update and the PID steps; a final state loads
// the output register, waiting there while the output is stalled.
// Reset: gains and distance per tick return to their defaults, error sums
// and previous errors clear, the output is empty and the input is ready.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_unit #(
	parameter int SUM_WIDTH = dwsp_pkg::SUM_WIDTH_DEF,
	parameter int CMD_LIMIT = dwsp_pkg::CMD_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dwsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dwsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// target_left[15:0], target_right[31:16], ticks_left[47:32],
	// ticks_right[63:48], interval_us[83:64], zero pad [87:84]
	input  logic [87:0]                       s_axis_tdata,
	// slip_mode[0], clear_sums[1]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// cmd_left[8:0], cmd_right[17:9], speed_left[33:18], speed_right[49:34],
	// zero pad [55:50]
	output logic [55:0]                       m_axis_tdata,
	// both_slipped[0], stalled[1]
	output logic [1:0]                        m_axis_tuser
);

	localparam int MUL_AW = (SUM_WIDTH > 31) ? SUM_WIDTH : 31;
	localparam int PROD_W = MUL_AW + dwsp_pkg::MUL_BW;
	localparam int ACC_W  = PROD_W + 2;
	localparam int PID_W  = ACC_W - 8;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_MUL_MM   = 4'd1;
	localparam logic [3:0] ST_MUL_TK   = 4'd2;
	localparam logic [3:0] ST_DIV_GO   = 4'd3;
	localparam logic [3:0] ST_DIV_WAIT = 4'd4;
	localparam logic [3:0] ST_ERR      = 4'd5;
	localparam logic [3:0] ST_PID_P    = 4'd6;
	localparam logic [3:0] ST_PID_I    = 4'd7;
	localparam logic [3:0] ST_PID_D    = 4'd8;
	localparam logic [3:0] ST_PID_S    = 4'd9;
	localparam logic [3:0] ST_PID_F    = 4'd10;
	localparam logic [3:0] ST_FIN      = 4'd11;

	logic [3:0]                 state_q;
	logic                       wsel_q;

	// configuration
	logic [15:0]                mm_q [2];
	logic signed [15:0]         gp_q;
	logic signed [15:0]         gi_q;
	logic signed [15:0]         gd_q;

	// latched request
	logic signed [15:0]         target_q [2];
	logic [15:0]                ticks_q [2];
	logic [19:0]                interval_q;
	logic                       slip_q;

	// loop state
	logic signed [SUM_WIDTH-1:0] sum_q [2];
	logic signed [16:0]          prev_q [2];

	// working registers
	logic signed [16:0]          err_q;
	logic signed [17:0]          d_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [15:0]          speed_q [2];
	logic [8:0]                  cmd_q [2];
	logic                        zero_q [2];
	logic                        stall_w_q [2];

	// output register
	logic                        m_tvalid_q;
	logic [55:0]                 m_tdata_q;
	logic [1:0]                  m_tuser_q;

	// shared units
	logic signed [MUL_AW-1:0]            mul_a;
	logic signed [dwsp_pkg::MUL_BW-1:0]  mul_b;
	logic signed [PROD_W-1:0]            mul_p;
	logic                                div_start;
	dwsp_pkg::div_stat_t                 div_stat;
	logic [dwsp_pkg::DIV_Q_W-1:0]        div_quo;

	logic                        s_acc;
	logic                        fin_load;
	logic [15:0]                 tk;
	logic [15:0]                 abs_tk;
	logic signed [15:0]          spd_c;
	logic signed [16:0]          err_c;
	logic signed [17:0]          d_c;
	logic signed [SUM_WIDTH:0]   sum_add;
	logic signed [SUM_WIDTH-1:0] sum_new;
	logic signed [PID_W-1:0]     pid_c;
	logic signed [PID_W-1:0]     pid_z;
	logic signed [PID_W-1:0]     pid_cl;
	logic                        big50;
	logic                        big100;
	logic                        slow_slip;
	logic                        slow_stall;
	logic                        zero_c;
	logic                        both_c;
	logic                        stall_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign fin_load      = (state_q == ST_FIN) && (!m_tvalid_q || m_axis_tready);
	assign div_start     = (state_q == ST_DIV_GO);

	assign tk     = ticks_q[wsel_q];
	assign abs_tk = tk[15] ? (~tk + 16'd1) : tk;

	// ---------------- shared multiplier operand select ----------------
	always_comb begin
		case (state_q)
			ST_MUL_MM: begin
				mul_a = MUL_AW'(mm_q[wsel_q]);
				mul_b = dwsp_pkg::SPD_SCALE;
			end
			ST_MUL_TK: begin
				mul_a = MUL_AW'(mul_p[dwsp_pkg::MM_PROD_W-1:0]);
				mul_b = dwsp_pkg::MUL_BW'(abs_tk);
			end
			ST_PID_P: begin
				mul_a = MUL_AW'(err_q);
				mul_b = dwsp_pkg::MUL_BW'(gp_q);
			end
			ST_PID_I: begin
				mul_a = MUL_AW'(sum_q[wsel_q]);
				mul_b = dwsp_pkg::MUL_BW'(gi_q);
			end
			ST_PID_D: begin
				mul_a = MUL_AW'(d_q);
				mul_b = dwsp_pkg::MUL_BW'(gd_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dwsp_mul #(
		.A_W (MUL_AW)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	dwsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_p[dwsp_pkg::SCALE_SHIFT +: dwsp_pkg::DIV_NUM_W]),
		.den    (interval_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// ---------------- speed, error and sum update ----------------
	always_comb begin
		if (interval_q == '0) begin
			spd_c = '0;
		end else if (tk[15]) begin
			spd_c = (div_stat.ovf || div_quo > dwsp_pkg::QUO_NEG_MAX) ?
				dwsp_pkg::SPEED_MIN : (~div_quo + 16'd1);
		end else begin
			spd_c = (div_stat.ovf || div_quo[15]) ? dwsp_pkg::SPEED_MAX : div_quo;
		end
	end

	assign err_c   = 17'(target_q[wsel_q]) - 17'(spd_c);
	assign d_c     = 18'(err_c) - 18'(prev_q[wsel_q]);
	assign sum_add = (SUM_WIDTH+1)'(sum_q[wsel_q]) + (SUM_WIDTH+1)'(err_c);

	always_comb begin
		if (sum_add[SUM_WIDTH] != sum_add[SUM_WIDTH-1]) begin
			sum_new = sum_add[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
				: {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_new = sum_add[SUM_WIDTH-1:0];
		end
	end

	// ---------------- command, slip and stall ----------------
	// arithmetic shift by 8 gives the floor of the sum of Q8.8 gain products
	assign pid_c      = acc_q[ACC_W-1:8];
	assign big50      = (pid_c >= dwsp_pkg::SLIP_CMD_MIN) || (pid_c <= -dwsp_pkg::SLIP_CMD_MIN);
	assign big100     = (pid_c > dwsp_pkg::STALL_CMD_MIN) || (pid_c < -dwsp_pkg::STALL_CMD_MIN);
	assign slow_slip  = (speed_q[wsel_q] <= dwsp_pkg::SLIP_SPD_LIM) &&
		(speed_q[wsel_q] >= -dwsp_pkg::SLIP_SPD_LIM);
	assign slow_stall = (speed_q[wsel_q] <= dwsp_pkg::STALL_SPD_LIM) &&
		(speed_q[wsel_q] >= -dwsp_pkg::STALL_SPD_LIM);
	assign zero_c     = slip_q && big50 && slow_slip;
	assign pid_z      = zero_c ? '0 : pid_c;

	always_comb begin
		if (pid_z > CMD_LIMIT) begin
			pid_cl = PID_W'(CMD_LIMIT);
		end else if (pid_z < -CMD_LIMIT) begin
			pid_cl = PID_W'(-CMD_LIMIT);
		end else begin
			pid_cl = pid_z;
		end
	end

	assign both_c  = slip_q && zero_q[0] && zero_q[1];
	assign stall_c = !slip_q && (stall_w_q[0] || stall_w_q[1]);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wsel_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_MUL_MM;
						wsel_q  <= 1'b0;
					end
				end
				ST_MUL_MM:   state_q <= ST_MUL_TK;
				ST_MUL_TK:   state_q <= ST_DIV_GO;
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR:      state_q <= ST_PID_P;
				ST_PID_P:    state_q <= ST_PID_I;
				ST_PID_I:    state_q <= ST_PID_D;
				ST_PID_D:    state_q <= ST_PID_S;
				ST_PID_S:    state_q <= ST_PID_F;
				ST_PID_F: begin
					if (wsel_q) begin
						state_q <= ST_FIN;
					end else begin
						wsel_q  <= 1'b1;
						state_q <= ST_MUL_MM;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q[0] <= dwsp_pkg::MM_RESET;
			mm_q[1] <= dwsp_pkg::MM_RESET;
			gp_q    <= dwsp_pkg::GAIN_P_RESET;
			gi_q    <= dwsp_pkg::GAIN_I_RESET;
			gd_q    <= dwsp_pkg::GAIN_D_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dwsp_pkg::REG_LEFT_MM:  mm_q[0] <= cfg_data;
				dwsp_pkg::REG_RIGHT_MM: mm_q[1] <= cfg_data;
				dwsp_pkg::REG_GAIN_P:   gp_q    <= cfg_data;
				dwsp_pkg::REG_GAIN_I:   gi_q    <= cfg_data;
				dwsp_pkg::REG_GAIN_D:   gd_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- loop state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0]  <= '0;
			sum_q[1]  <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else if (s_acc && s_axis_tuser[1]) begin
			sum_q[0]  <= '0;
			sum_q[1]  <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else if (state_q == ST_ERR) begin
			sum_q[wsel_q]  <= sum_new;
			prev_q[wsel_q] <= err_c;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_acc) begin
			target_q[0] <= s_axis_tdata[15:0];
			target_q[1] <= s_axis_tdata[31:16];
			ticks_q[0]  <= s_axis_tdata[47:32];
			ticks_q[1]  <= s_axis_tdata[63:48];
			interval_q  <= s_axis_tdata[83:64];
			slip_q      <= s_axis_tuser[0];
		end
		case (state_q)
			ST_ERR: begin
				speed_q[wsel_q] <= spd_c;
				err_q           <= err_c;
				d_q             <= d_c;
			end
			ST_PID_I: acc_q <= ACC_W'(mul_p);
			ST_PID_D: acc_q <= acc_q + ACC_W'(mul_p);
			ST_PID_S: acc_q <= acc_q + ACC_W'(mul_p);
			ST_PID_F: begin
				cmd_q[wsel_q]     <= pid_cl[8:0];
				zero_q[wsel_q]    <= zero_c || (pid_c == '0);
				stall_w_q[wsel_q] <= big100 && slow_stall;
			end
			default: ;
		endcase
		if (fin_load) begin
			m_tdata_q <= {6'b0, speed_q[1], speed_q[0], cmd_q[1], cmd_q[0]};
			m_tuser_q <= {stall_c, both_c};
		end
	end

	// ---------------- output handshake ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result presented without finishing the sequence");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_clear_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tuser[1]) |=>
		(sum_q[0] == '0 && sum_q[1] == '0 && prev_q[0] == '0 && prev_q[1] == '0))
		else $error("loop state not cleared on clear request");
`endif

endmodule
